>>> src/plts_pkg.sv
// ----------------------------------------------------------------------------
// plts_pkg
// Shared types and constants of the token scanner: token kinds, the command
// word passed from the front end to the back end, and the run-done status.
// ----------------------------------------------------------------------------
package plts_pkg;

    // lexeme buffer length, default and upper bound of its count width
    localparam int LEX_MAX_DEF   = 32;
    localparam int CNT_W         = 6;   // holds counts up to 63
    localparam int CMD_DEPTH_DEF = 2;

    localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        K_READ   = 4'd0,
        K_WRITE  = 4'd1,
        K_ID     = 4'd2,
        K_NUMBER = 4'd3,
        K_LPAREN = 4'd4,
        K_RPAREN = 4'd5,
        K_SEMI   = 4'd6,
        K_COMMA  = 4'd7,
        K_ASSIGN = 4'd8,
        K_PLUS   = 4'd9,
        K_MINUS  = 4'd10,
        K_TIMES  = 4'd11,
        K_DIV    = 4'd12,
        K_EOF    = 4'd13,
        K_ERROR  = 4'd14
    } t_kind;

    // one token for the back end; run = identifier bytes to be read back
    typedef struct packed {
        t_kind              kind;
        logic [30:0]        value;
        logic [7:0]         ch;
        logic               trunc;
        logic               run;
        logic               bank;
        logic [CNT_W-1:0]   len;
    } t_cmd;

    // back end has finished reading a lexeme bank
    typedef struct packed {
        logic valid;
        logic bank;
    } t_done;

endpackage

>>> src/plts_ram.sv
// ----------------------------------------------------------------------------
// plts_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module plts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/plts_cmd_fifo.sv
// ----------------------------------------------------------------------------
// plts_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module plts_cmd_fifo #(
    parameter int DEPTH = plts_pkg::CMD_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  plts_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output plts_pkg::t_cmd  o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    plts_pkg::t_cmd r_slot [DEPTH];
    logic [PW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/plts_front.sv
// ----------------------------------------------------------------------------
// plts_front
// Front end: classify each byte, track the scan mode, build numbers, write
// lexeme bytes into a ping-pong buffer and issue token commands.
// ----------------------------------------------------------------------------
module plts_front #(
    parameter int LEX_MAX = plts_pkg::LEX_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_char_in,
    input  logic                          i_end_of_input,
    // command queue
    output logic                          o_cmd_push,
    output plts_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_full,
    // lexeme buffer write
    output logic                          o_we,
    output logic [$clog2(2*LEX_MAX)-1:0]  o_waddr,
    output logic [7:0]                    o_wdata,
    input  plts_pkg::t_done               i_done
);

    localparam int CW = $clog2(LEX_MAX + 1);
    localparam int AW = $clog2(2 * LEX_MAX);

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [1:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_COLON
    } t_mode;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO && c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // expected keyword byte at a lexeme position
    function automatic logic [7:0] kw_read_ch(input logic [CW-1:0] k);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            CW'(0):  ch = 8'h72;
            CW'(1):  ch = 8'h65;
            CW'(2):  ch = 8'h61;
            CW'(3):  ch = 8'h64;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] kw_write_ch(input logic [CW-1:0] k);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            CW'(0):  ch = 8'h77;
            CW'(1):  ch = 8'h72;
            CW'(2):  ch = 8'h69;
            CW'(3):  ch = 8'h74;
            CW'(4):  ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    t_mode           r_mode, n_mode;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [30:0]     r_val, n_val;
    logic            r_ovf, n_ovf;
    logic            r_mrd, n_mrd;
    logic            r_mwr, n_mwr;
    logic            r_wbank, n_wbank;
    logic [1:0]      r_busy, n_busy;
    logic            r_pend, n_pend;
    plts_pkg::t_cmd  r_pend_cmd, n_pend_cmd;

    logic            accept;
    logic            do_flush, do_clear, do_idle, do_append;
    logic            flush_run, kw_rd, kw_wr;
    logic            a_v, b_v;
    plts_pkg::t_cmd  a_cmd, b_cmd, flush_cmd;
    logic [34:0]     v10;
    logic [30:0]     digit;

    assign full   = r_pend || i_cmd_full || r_busy[r_wbank] ||
                    (r_mode == M_IDENT && r_busy[~r_wbank]);
    assign accept = push && !full;
    assign digit  = {23'd0, i_char_in - CH_ZERO};
    assign v10    = {1'b0, r_val, 3'b000} + {3'b000, r_val, 1'b0} + {4'd0, digit};

    // pending token as it would be flushed now
    always_comb begin
        kw_rd     = !r_ovf && (r_cnt == CW'(4)) && r_mrd;
        kw_wr     = !r_ovf && (r_cnt == CW'(5)) && r_mwr;
        flush_run = 1'b0;
        flush_cmd = '{kind: plts_pkg::K_ERROR, value: '0, ch: '0, trunc: 1'b0,
                      run: 1'b0, bank: r_wbank, len: '0};
        unique case (r_mode)
            M_IDENT: begin
                if (kw_rd) begin
                    flush_cmd.kind = plts_pkg::K_READ;
                end else if (kw_wr) begin
                    flush_cmd.kind = plts_pkg::K_WRITE;
                end else begin
                    flush_run       = 1'b1;
                    flush_cmd.kind  = plts_pkg::K_ID;
                    flush_cmd.run   = 1'b1;
                    flush_cmd.trunc = r_ovf;
                    flush_cmd.len   = plts_pkg::CNT_W'(r_cnt);
                end
            end
            M_NUMBER: begin
                flush_cmd.kind  = plts_pkg::K_NUMBER;
                flush_cmd.value = r_val;
            end
            M_COLON: begin
                flush_cmd.ch = CH_COLON;
            end
            M_IDLE: begin
                flush_cmd.kind = plts_pkg::K_ERROR;
            end
            default: begin
                flush_cmd.kind = plts_pkg::K_ERROR;
            end
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_cnt      = r_cnt;
        n_val      = r_val;
        n_ovf      = r_ovf;
        n_mrd      = r_mrd;
        n_mwr      = r_mwr;
        n_wbank    = r_wbank;
        n_busy     = r_busy;
        n_pend     = r_pend;
        n_pend_cmd = r_pend_cmd;
        do_flush   = 1'b0;
        do_clear   = 1'b0;
        do_idle    = 1'b0;
        do_append  = 1'b0;
        a_v        = 1'b0;
        b_v        = 1'b0;
        a_cmd      = flush_cmd;
        b_cmd      = '{kind: plts_pkg::K_EOF, value: '0, ch: '0, trunc: 1'b0,
                       run: 1'b0, bank: 1'b0, len: '0};
        o_we       = 1'b0;
        o_waddr    = '0;
        o_wdata    = i_char_in;
        o_cmd_push = 1'b0;
        o_cmd      = r_pend_cmd;

        if (i_done.valid) begin
            n_busy[i_done.bank] = 1'b0;
        end

        if (accept) begin
            if (i_end_of_input) begin
                do_flush = (r_mode != M_IDLE);
                do_clear = 1'b1;
                b_v      = 1'b1;
            end else begin
                unique case (r_mode)
                    M_IDENT: begin
                        if (is_letter(i_char_in) || is_digit(i_char_in)) begin
                            do_append = 1'b1;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    M_NUMBER: begin
                        if (is_digit(i_char_in)) begin
                            n_val     = (v10 > {4'd0, plts_pkg::VAL_MAX}) ?
                                        plts_pkg::VAL_MAX : v10[30:0];
                            do_append = 1'b1;
                        end else if (is_letter(i_char_in)) begin
                            n_mode    = M_IDENT;
                            n_val     = '0;
                            do_append = 1'b1;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    M_COLON: begin
                        if (i_char_in == CH_EQUAL) begin
                            do_clear   = 1'b1;
                            b_v        = 1'b1;
                            b_cmd.kind = plts_pkg::K_ASSIGN;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    M_IDLE: begin
                        do_idle = 1'b1;
                    end
                    default: begin
                        do_idle = 1'b1;
                    end
                endcase
            end
        end

        // retire the pending token; a lexeme run locks its bank until read back
        if (do_flush) begin
            a_v = 1'b1;
            if (flush_run) begin
                n_busy[r_wbank] = 1'b1;
                n_wbank         = ~r_wbank;
            end
        end
        if (do_flush || do_clear) begin
            n_mode = M_IDLE;
            n_cnt  = '0;
            n_val  = '0;
            n_ovf  = 1'b0;
            n_mrd  = 1'b1;
            n_mwr  = 1'b1;
        end

        // start of a fresh token
        if (do_idle && !is_space(i_char_in)) begin
            if (is_letter(i_char_in)) begin
                n_mode    = M_IDENT;
                do_append = 1'b1;
            end else if (is_digit(i_char_in)) begin
                n_mode    = M_NUMBER;
                n_val     = digit;
                do_append = 1'b1;
            end else begin
                b_v = 1'b1;
                case (i_char_in)
                    CH_PLUS:   b_cmd.kind = plts_pkg::K_PLUS;
                    CH_MINUS:  b_cmd.kind = plts_pkg::K_MINUS;
                    CH_STAR:   b_cmd.kind = plts_pkg::K_TIMES;
                    CH_SLASH:  b_cmd.kind = plts_pkg::K_DIV;
                    CH_SEMI:   b_cmd.kind = plts_pkg::K_SEMI;
                    CH_COMMA:  b_cmd.kind = plts_pkg::K_COMMA;
                    CH_LPAREN: b_cmd.kind = plts_pkg::K_LPAREN;
                    CH_RPAREN: b_cmd.kind = plts_pkg::K_RPAREN;
                    CH_COLON: begin
                        n_mode = M_COLON;
                        b_v    = 1'b0;
                    end
                    default: begin
                        b_cmd.kind = plts_pkg::K_ERROR;
                        b_cmd.ch   = i_char_in;
                    end
                endcase
            end
        end

        // append to the lexeme buffer, drop and flag past its end
        if (do_append) begin
            if (n_cnt < CW'(LEX_MAX)) begin
                o_we    = 1'b1;
                o_waddr = n_wbank ? AW'(LEX_MAX) + AW'(n_cnt) : AW'(n_cnt);
                n_mrd   = n_mrd && (i_char_in == kw_read_ch(n_cnt));
                n_mwr   = n_mwr && (i_char_in == kw_write_ch(n_cnt));
                n_cnt   = n_cnt + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end

        // issue commands: the second one of a pair waits in the pending register
        if (r_pend) begin
            o_cmd_push = !i_cmd_full;
            o_cmd      = r_pend_cmd;
            n_pend     = i_cmd_full;
        end else if (a_v) begin
            o_cmd_push = 1'b1;
            o_cmd      = a_cmd;
            n_pend     = b_v;
            n_pend_cmd = b_cmd;
        end else if (b_v) begin
            o_cmd_push = 1'b1;
            o_cmd      = b_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_mrd      <= n_mrd;
        r_mwr      <= n_mwr;
        r_pend_cmd <= n_pend_cmd;
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_cnt   <= '0;
            r_val   <= '0;
            r_ovf   <= 1'b0;
            r_mrd   <= 1'b1;
            r_mwr   <= 1'b1;
            r_wbank <= 1'b0;
            r_busy  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
            r_pend  <= n_pend;
        end
    end

endmodule

>>> src/plts_back.sv
// ----------------------------------------------------------------------------
// plts_back
// Back end: take commands from the queue, read identifier runs back from
// the lexeme buffer and present results through an output register.
// ----------------------------------------------------------------------------
module plts_back #(
    parameter int LEX_MAX = plts_pkg::LEX_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_empty,
    input  plts_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_re,
    output logic [$clog2(2*LEX_MAX)-1:0]  o_raddr,
    input  logic [7:0]                    i_rdata,
    output plts_pkg::t_done               o_done,
    output logic                          empty,
    input  logic                          pop,
    output logic [3:0]                    o_token_kind,
    output logic [30:0]                   o_number_value,
    output logic [7:0]                    o_char_out,
    output logic                          o_truncated,
    output logic                          o_last
);

    localparam int CW = $clog2(LEX_MAX + 1);
    localparam int AW = $clog2(2 * LEX_MAX);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REQ,
        S_WAIT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_len;
    logic            r_bank;
    logic            r_trunc;
    logic            r_out_valid;
    plts_pkg::t_kind r_kind;
    logic [30:0]     r_value;
    logic [7:0]      r_ch;
    logic            r_otrunc;
    logic            r_last;
    plts_pkg::t_done r_done;

    logic out_free;
    logic run_last;

    assign out_free  = !r_out_valid || pop;
    assign run_last  = (r_idx + 1'b1) == r_len;
    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty && (i_cmd.run || out_free);
    assign o_re      = (r_state == S_REQ);
    assign o_raddr   = r_bank ? AW'(LEX_MAX) + AW'(r_idx) : AW'(r_idx);
    assign o_done    = r_done;

    assign empty          = !r_out_valid;
    assign o_token_kind   = r_kind;
    assign o_number_value = r_value;
    assign o_char_out     = r_ch;
    assign o_truncated    = r_otrunc;
    assign o_last         = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            r_done.valid <= 1'b0;
            if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.run) begin
                            r_idx   <= '0;
                            r_len   <= CW'(i_cmd.len);
                            r_bank  <= i_cmd.bank;
                            r_trunc <= i_cmd.trunc;
                            r_state <= S_REQ;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_kind      <= i_cmd.kind;
                            r_value     <= i_cmd.value;
                            r_ch        <= i_cmd.ch;
                            r_otrunc    <= i_cmd.trunc;
                            r_last      <= 1'b1;
                        end
                    end
                end
                S_REQ: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= plts_pkg::K_ID;
                        r_value     <= '0;
                        r_ch        <= i_rdata;
                        r_otrunc    <= r_trunc;
                        r_last      <= run_last;
                        if (run_last) begin
                            r_done.valid <= 1'b1;
                            r_done.bank  <= r_bank;
                            r_state      <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_REQ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/pl_token_scanner_core.sv
// ----------------------------------------------------------------------------
// pl_token_scanner_core
// Streaming lexical scanner: source bytes in, token words out.
// ----------------------------------------------------------------------------
// Path: a single-word token goes into the command queue, then into the
//   output register, once the word that completes it is taken.
// Throughput: one input word a cycle while a token builds and full is low; a
//   word that closes a token and is a token itself issues two commands.
// Identifier runs leave one byte at a time (buffer read, then output
//   register load); the next run waits for its buffer bank.
// Reset: synchronous, active low; clears scan and queue state. The lexeme
//   buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module pl_token_scanner_core #(
    parameter int LEX_MAX   = plts_pkg::LEX_MAX_DEF,
    parameter int CMD_DEPTH = plts_pkg::CMD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word: source byte or end-of-input marker
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_input,
    // result word
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_token_kind,
    output logic [30:0] o_number_value,
    output logic [7:0]  o_char_out,
    output logic        o_truncated,
    output logic        o_last
);

    localparam int AW = $clog2(2 * LEX_MAX);

    // front end to command queue
    logic            cmd_push;
    plts_pkg::t_cmd  cmd_in;
    logic            cmd_full;
    // command queue to back end
    logic            cmd_pop;
    logic            cmd_empty;
    plts_pkg::t_cmd  cmd_head;
    // lexeme buffer ports: two banks, front writes one while back reads the other
    logic            buf_we;
    logic [AW-1:0]   buf_waddr;
    logic [7:0]      buf_wdata;
    logic            buf_re;
    logic [AW-1:0]   buf_raddr;
    logic [7:0]      buf_rdata;
    // bank release from back end
    plts_pkg::t_done run_done;

    // Classify bytes, keep scan mode, write lexeme bytes, issue commands.
    plts_front #(
        .LEX_MAX (LEX_MAX)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_char_in      (i_char_in),
        .i_end_of_input (i_end_of_input),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd_in),
        .i_cmd_full     (cmd_full),
        .o_we           (buf_we),
        .o_waddr        (buf_waddr),
        .o_wdata        (buf_wdata),
        .i_done         (run_done)
    );

    // Decouple the two halves so each can stall on its own.
    plts_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_head  (cmd_head)
    );

    // Ping-pong lexeme buffer, LEX_MAX bytes a bank.
    plts_ram #(
        .WIDTH (8),
        .DEPTH (2 * LEX_MAX)
    ) u_lex_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_re    (buf_re),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    // Carry out commands and hold the result word until popped.
    plts_back #(
        .LEX_MAX (LEX_MAX)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_empty    (cmd_empty),
        .i_cmd          (cmd_head),
        .o_cmd_pop      (cmd_pop),
        .o_re           (buf_re),
        .o_raddr        (buf_raddr),
        .i_rdata        (buf_rdata),
        .o_done         (run_done),
        .empty          (empty),
        .pop            (pop),
        .o_token_kind   (o_token_kind),
        .o_number_value (o_number_value),
        .o_char_out     (o_char_out),
        .o_truncated    (o_truncated),
        .o_last         (o_last)
    );

endmodule

>>> verif/tb_pl_token_scanner_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pl_token_scanner_core
// Self-checking bench for the streaming token scanner. Source bytes go in
// through the push/full side. A behavioural scanner in the bench rebuilds
// every token word that each byte completes. A checker process compares
// each word popped from the result side, field by field, with the oldest
// prediction. Directed, back-pressure and random token streams run in turn.
// ----------------------------------------------------------------------------
module tb_pl_token_scanner_core;
    import plts_pkg::*;

    localparam int LEX_LEN     = LEX_MAX_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_PRINTS  = 30;
    localparam int LONG_HOLD   = 400;    // receiver hold-off for the back-pressure test

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_COLON
    } t_scan;

    // one token word as it should leave the block
    typedef struct packed {
        t_kind       kind;
        logic [30:0] value;
        logic [7:0]  ch;
        logic        trunc;
        logic        last;
    } t_token_word;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_char_in;
    logic        i_end_of_input;
    logic        empty;
    logic        pop;
    logic [3:0]  o_token_kind;
    logic [30:0] o_number_value;
    logic [7:0]  o_char_out;
    logic        o_truncated;
    logic        o_last;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // behavioural scanner: pending token and the words predicted so far
    t_scan       scan_state;
    logic [7:0]  lex_buf [LEX_LEN];
    int          lex_len;
    logic [30:0] num_acc;
    bit          lex_overflow;
    t_token_word token_fifo [$];

    // idling and hold-off controls
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold_left = 0;

    // bookkeeping
    int          mismatches = 0;
    int          words_sent = 0;
    int          random_words = 0;
    int          words_checked = 0;
    int          trunc_words = 0;
    int          full_stalls = 0;
    int          cycle_count = 0;
    logic [15:0] kinds_seen = '0;

    string       op_chars = "+-*/;,()";
    logic [7:0]  blank_chars [6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};

    pl_token_scanner_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_char_in      (i_char_in),
        .i_end_of_input (i_end_of_input),
        .empty          (empty),
        .pop            (pop),
        .o_token_kind   (o_token_kind),
        .o_number_value (o_number_value),
        .o_char_out     (o_char_out),
        .o_truncated    (o_truncated),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------------
    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // space, tab, LF, VT, FF and CR
    function automatic bit is_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // ------------------------------------------------------------------------
    // Behavioural scanner
    // ------------------------------------------------------------------------
    function automatic void add_token(t_kind kind, logic [30:0] value, logic [7:0] ch,
                                      bit trunc, bit last);
        t_token_word w;
        w.kind  = kind;
        w.value = value;
        w.ch    = ch;
        w.trunc = trunc;
        w.last  = last;
        token_fifo.push_back(w);
    endfunction

    function automatic void clear_pending();
        scan_state   = SCAN_IDLE;
        lex_len      = 0;
        num_acc      = '0;
        lex_overflow = 1'b0;
    endfunction

    // keep the byte while there is room, otherwise drop it and mark the token
    function automatic void hold_byte(logic [7:0] c);
        if (lex_len < LEX_LEN) begin
            lex_buf[lex_len] = c;
            lex_len++;
        end else begin
            lex_overflow = 1'b1;
        end
    endfunction

    function automatic bit lexeme_matches(string kw);
        if (lex_overflow || lex_len != kw.len())
            return 1'b0;
        for (int i = 0; i < lex_len; i++)
            if (lex_buf[i] != kw[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // emit whatever token is pending and fall back to idle
    function automatic void flush_pending();
        case (scan_state)
            SCAN_IDENT: begin
                if (lexeme_matches("read"))
                    add_token(K_READ, '0, '0, 1'b0, 1'b1);
                else if (lexeme_matches("write"))
                    add_token(K_WRITE, '0, '0, 1'b0, 1'b1);
                else
                    for (int i = 0; i < lex_len; i++)
                        add_token(K_ID, '0, lex_buf[i], lex_overflow, i == lex_len - 1);
            end
            SCAN_NUMBER: add_token(K_NUMBER, num_acc, '0, 1'b0, 1'b1);
            SCAN_COLON:  add_token(K_ERROR, '0, ":", 1'b0, 1'b1);
            default: ;
        endcase
        clear_pending();
    endfunction

    function automatic void scan_from_idle(logic [7:0] c);
        t_kind op_kind;
        if (is_blank(c))
            return;
        if (is_letter(c)) begin
            scan_state = SCAN_IDENT;
            hold_byte(c);
            return;
        end
        if (is_digit(c)) begin
            scan_state = SCAN_NUMBER;
            hold_byte(c);
            num_acc = c - "0";
            return;
        end
        case (c)
            "+": op_kind = K_PLUS;
            "-": op_kind = K_MINUS;
            "*": op_kind = K_TIMES;
            "/": op_kind = K_DIV;
            ";": op_kind = K_SEMI;
            ",": op_kind = K_COMMA;
            "(": op_kind = K_LPAREN;
            ")": op_kind = K_RPAREN;
            ":": begin
                scan_state = SCAN_COLON;
                return;
            end
            default: begin
                add_token(K_ERROR, '0, c, 1'b0, 1'b1);
                return;
            end
        endcase
        add_token(op_kind, '0, '0, 1'b0, 1'b1);
    endfunction

    // work out the token words that one accepted input word completes
    function automatic void predict_tokens(logic [7:0] c, bit eoi);
        longint unsigned acc_wide;
        if (eoi) begin
            flush_pending();
            add_token(K_EOF, '0, '0, 1'b0, 1'b1);
            return;
        end
        case (scan_state)
            SCAN_IDENT: begin
                if (is_letter(c) || is_digit(c)) begin
                    hold_byte(c);
                    return;
                end
                flush_pending();
            end
            SCAN_NUMBER: begin
                if (is_digit(c)) begin
                    acc_wide = num_acc;
                    acc_wide = acc_wide * 10 + c - 8'd48;
                    num_acc  = (acc_wide > VAL_MAX) ? VAL_MAX : acc_wide[30:0];
                    hold_byte(c);
                    return;
                end
                // a letter straight after digits turns the number into a name
                if (is_letter(c)) begin
                    scan_state = SCAN_IDENT;
                    num_acc    = '0;
                    hold_byte(c);
                    return;
                end
                flush_pending();
            end
            SCAN_COLON: begin
                if (c == "=") begin
                    clear_pending();
                    add_token(K_ASSIGN, '0, '0, 1'b0, 1'b1);
                    return;
                end
                // bad colon: report it, then rescan this byte from idle
                flush_pending();
            end
            default: ;
        endcase
        scan_from_idle(c);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Offer one word and hold it until taken. Push stays high afterwards so
    // that back-to-back words never drop it; a gap lowers it at the next call.
    task automatic send_byte(logic [7:0] c, bit eoi);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_char_in      <= c;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (full);
        predict_tokens(c, eoi);
        if (eoi || !is_blank(c))
            words_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // end of input with a random byte on the ignored data lines
    task automatic send_eof();
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] rand_letter();
        int k;
        k = $urandom_range(52);
        if (k < 26)
            return "a" + k;
        if (k < 52)
            return "A" + k - 26;
        return "_";
    endfunction

    function automatic logic [7:0] rand_name_char();
        if ($urandom_range(9) < 3)
            return "0" + $urandom_range(9);
        return rand_letter();
    endfunction

    task automatic send_ident(int len);
        send_byte(rand_letter(), 1'b0);
        for (int i = 1; i < len; i++)
            send_byte(rand_name_char(), 1'b0);
    endtask

    task automatic send_digits(int len);
        for (int i = 0; i < len; i++)
            send_byte("0" + $urandom_range(9), 1'b0);
    endtask

    // Pause the sender until every predicted word has come back. Always
    // advance the clock before returning so push is never lowered and raised in one step.
    task automatic wait_for_tokens();
        push <= 1'b0;
        do @(posedge i_clk); while (token_fifo.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: pop at random, or hold off for a counted stretch
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            pop <= 1'b0;
            rx_hold_left--;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare every popped word with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin : check_word
        t_token_word want;
        if (i_rst_n && pop && !empty) begin
            kinds_seen[o_token_kind] = 1'b1;
            if (o_truncated)
                trunc_words++;
            if (token_fifo.size() == 0) begin
                report_mismatch($sformatf("word of kind %0d with nothing predicted",
                                          o_token_kind));
            end else begin
                want = token_fifo.pop_front();
                words_checked++;
                if (o_token_kind != want.kind)
                    report_mismatch($sformatf("word %0d: kind %0d, expected %0d",
                                              words_checked, o_token_kind, want.kind));
                if (o_number_value != want.value)
                    report_mismatch($sformatf("word %0d: value %0d, expected %0d",
                                              words_checked, o_number_value, want.value));
                if (o_char_out != want.ch)
                    report_mismatch($sformatf("word %0d: char %02h, expected %02h",
                                              words_checked, o_char_out, want.ch));
                if (o_truncated != want.trunc)
                    report_mismatch($sformatf("word %0d: truncated %0b, expected %0b",
                                              words_checked, o_truncated, want.trunc));
                if (o_last != want.last)
                    report_mismatch($sformatf("word %0d: last %0b, expected %0b",
                                              words_checked, o_last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Cycle counter and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (push && full)
            full_stalls++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles, %0d words still predicted",
                     cycle_count, token_fifo.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // both keywords, every operator and the assignment, then end of input
    task automatic test_tokens();
        send_text("read(write)+-*/;,:=");
        send_eof();
    endtask

    // bad colon before a letter, every whitespace byte, bytes at both ends
    // of the range, a number turned name, near-keywords, a bad colon at end
    // of input and an end of input with nothing pending
    task automatic test_special_cases();
        send_text(":a 9z rea writex 0");
        foreach (blank_chars[i])
            send_byte(blank_chars[i], 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("::");
        send_eof();
        send_eof();
    endtask

    // Hold the receiver off for a long stretch while a burst of short tokens
    // fills the block and stalls its input; then long names at and beyond the
    // buffer length, and numbers at and past the saturation point.
    task automatic test_backpressure();
        rx_hold_left = LONG_HOLD;
        for (int i = 0; i < 30; i++)
            send_byte(op_chars[$urandom_range(7)], 1'b0);
        send_ident(LEX_LEN);
        send_byte(" ", 1'b0);
        send_ident(LEX_LEN + 1);
        send_byte(";", 1'b0);
        send_ident(LEX_LEN + 8);
        send_byte(" ", 1'b0);
        send_text("2147483647 2147483648 99999999999");
        send_byte(",", 1'b0);
        // digits past the buffer length, then a letter: a truncated name
        send_digits(LEX_LEN + 2);
        send_byte("q", 1'b0);
        send_eof();
        wait_for_tokens();
    endtask

    // one token of random content; mostly well-formed, some noise
    task automatic send_random_token();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 22) begin
            len = ($urandom_range(15) == 0) ? $urandom_range(LEX_LEN + 6, LEX_LEN - 2)
                                            : $urandom_range(8, 1);
            send_ident(len);
        end else if (pick < 30) begin
            if ($urandom_range(1))
                send_text("read");
            else
                send_text("write");
        end else if (pick < 44) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(13, 10) : $urandom_range(5, 1);
            send_digits(len);
            if ($urandom_range(4) == 0)
                send_byte(rand_letter(), 1'b0);
        end else if (pick < 68) begin
            send_byte(op_chars[$urandom_range(7)], 1'b0);
        end else if (pick < 74) begin
            send_text(":=");
        end else if (pick < 79) begin
            send_byte(":", 1'b0);
            send_byte(8'($urandom_range(255)), 1'b0);
        end else if (pick < 84) begin
            send_eof();
        end else begin
            send_byte(8'($urandom_range(255)), 1'b0);
        end
        if ($urandom_range(1))
            send_byte(blank_chars[$urandom_range(5)], 1'b0);
    endtask

    task automatic test_random_stream(int tx_pct, int rx_pct, int n_words);
        int start;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = words_sent;
        while (words_sent - start < n_words)
            send_random_token();
        // close the stream so nothing is left pending between phases
        send_eof();
        random_words += words_sent - start;
        wait_for_tokens();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        pop            <= 1'b0;
        i_char_in      <= '0;
        i_end_of_input <= 1'b0;
        clear_pending();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        tx_idle_pct = 16;
        rx_idle_pct = 60;
        test_tokens();
        test_special_cases();
        wait_for_tokens();
        test_random_stream(16, 60, 40);

        // the other way round, then no idling at all
        test_random_stream(60, 16, 40);
        test_random_stream(0, 0, 40);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();

        // drain, then give stray words time to show up
        wait_for_tokens();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d source words (%0d random) and %0d token words in %0d cycles",
                 words_sent, random_words, words_checked, cycle_count);
        $display("Token kinds seen: %0d of 15; truncated name bytes: %0d; full stalls: %0d",
                 $countones(kinds_seen), trunc_words, full_stalls);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
src/plts_pkg.sv
src/plts_ram.sv
src/plts_cmd_fifo.sv
src/plts_front.sv
src/plts_back.sv
src/pl_token_scanner_core.sv
verif/tb_pl_token_scanner_core.sv
